// ===== rtl/core/psq_pkg.sv =====
// Shared types and constants for the positional sequence store.
`timescale 1ns / 1ps
`default_nettype none
package psq_pkg;

  localparam int MAX_RESULTS = 32;

  localparam logic [2:0] CMD_INSERT    = 3'd0;
  localparam logic [2:0] CMD_REMOVE    = 3'd1;
  localparam logic [2:0] CMD_READ      = 3'd2;
  localparam logic [2:0] CMD_COUNT     = 3'd3;
  localparam logic [2:0] CMD_LIST_FWD  = 3'd4;
  localparam logic [2:0] CMD_LIST_BWD  = 3'd5;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_ERR   = 2'd1;
  localparam logic [1:0] ST_EMPTY = 2'd2;

  typedef struct packed {
    logic [2:0]         cmd;
    logic [5:0]         position;
    logic signed [31:0] new_value;
  } req_t;

  typedef struct packed {
    logic signed [31:0] data;
    logic [1:0]         status;
    logic               last;
  } rsp_t;

  typedef struct packed {
    logic accept;
    logic list_step;
  } ctrl_t;

  typedef struct packed {
    logic out_free;
    logic list_start;
    logic list_last;
  } stat_t;

endpackage
`default_nettype wire

// ===== rtl/core/psq_ctrl.sv =====
// Controller state machine: request acceptance and listing sequencing.
`timescale 1ns / 1ps
`default_nettype none
module psq_ctrl (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           req_valid,
  output logic                req_ready,
  input  wire psq_pkg::stat_t stat,
  output psq_pkg::ctrl_t      ctrl
);

  localparam logic S_IDLE = 1'b0;
  localparam logic S_LIST = 1'b1;

  logic state;
  logic state_next;

  assign req_ready      = (state == S_IDLE) && stat.out_free;
  assign ctrl.accept    = req_valid && req_ready;
  assign ctrl.list_step = (state == S_LIST) && stat.out_free;

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (ctrl.accept && stat.list_start) state_next = S_LIST;
      end
      S_LIST: begin
        if (ctrl.list_step && stat.list_last) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/core/psq_datapath.sv =====
// Datapath: shifting cells, count, listing pointer and result register.
`timescale 1ns / 1ps
`default_nettype none
module psq_datapath #(
  parameter int CAPACITY = 32
) (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire psq_pkg::req_t  req,
  input  wire psq_pkg::ctrl_t ctrl,
  output psq_pkg::stat_t      stat,
  output logic                rsp_valid,
  input  wire logic           rsp_ready,
  output psq_pkg::rsp_t       rsp
);

  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam int IDX_W = $clog2(CAPACITY);
  localparam int CMP_W = (CNT_W > 6) ? CNT_W : 6;
  localparam int REM_W = $clog2(psq_pkg::MAX_RESULTS + 1);

  logic signed [31:0] cell_q [CAPACITY];
  logic [CNT_W-1:0]   count;
  logic [IDX_W-1:0]   ptr;
  logic [REM_W-1:0]   rem;
  logic [REM_W-1:0]   rem_init;
  logic               backward;
  logic [CMP_W-1:0]   pos_x;
  logic [CMP_W-1:0]   count_x;
  logic               ins_ok;
  logic               pos_ok;
  logic               is_list;
  logic               do_ins;
  logic               do_rem;
  logic [IDX_W-1:0]   rd_idx;
  logic signed [31:0] rd_data;
  logic               emit;
  psq_pkg::rsp_t      rsp_next;

  assign pos_x   = CMP_W'(req.position);
  assign count_x = CMP_W'(count);
  assign ins_ok  = (pos_x <= count_x) && (count_x < CMP_W'(CAPACITY));
  assign pos_ok  = pos_x < count_x;
  assign is_list = (req.cmd == psq_pkg::CMD_LIST_FWD) || (req.cmd == psq_pkg::CMD_LIST_BWD);
  assign do_ins  = ctrl.accept && (req.cmd == psq_pkg::CMD_INSERT) && ins_ok;
  assign do_rem  = ctrl.accept && (req.cmd == psq_pkg::CMD_REMOVE) && pos_ok;

  assign rem_init = (count_x > CMP_W'(psq_pkg::MAX_RESULTS)) ?
                    REM_W'(psq_pkg::MAX_RESULTS) : REM_W'(count);

  assign stat.out_free   = !rsp_valid || rsp_ready;
  assign stat.list_start = is_list && (count != '0);
  assign stat.list_last  = rem == REM_W'(1);

  assign rd_idx  = ctrl.list_step ? ptr : req.position[IDX_W-1:0];
  assign rd_data = cell_q[rd_idx];

  genvar g;
  for (g = 0; g < CAPACITY; g++) begin : g_cell
    logic signed [31:0] word;
    logic signed [31:0] from_below;
    logic signed [31:0] from_above;

    if (g > 0) begin : g_below
      assign from_below = cell_q[g-1];
    end else begin : g_no_below
      assign from_below = '0;
    end
    if (g < CAPACITY - 1) begin : g_above
      assign from_above = cell_q[g+1];
    end else begin : g_no_above
      assign from_above = '0;
    end

    always_ff @(posedge clk) begin
      if (do_ins) begin
        if (CMP_W'(g) > pos_x) begin
          word <= from_below;
        end else if (CMP_W'(g) == pos_x) begin
          word <= req.new_value;
        end
      end else if (do_rem && (CMP_W'(g) >= pos_x)) begin
        word <= from_above;
      end
    end

    assign cell_q[g] = word;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (do_ins) begin
      count <= count + 1'b1;
    end else if (do_rem) begin
      count <= count - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rem <= '0;
    end else if (ctrl.accept && stat.list_start) begin
      rem <= rem_init;
    end else if (ctrl.list_step) begin
      rem <= rem - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.accept && stat.list_start) begin
      backward <= req.cmd == psq_pkg::CMD_LIST_BWD;
      ptr      <= (req.cmd == psq_pkg::CMD_LIST_BWD) ? IDX_W'(count - 1'b1) : '0;
    end else if (ctrl.list_step) begin
      ptr <= backward ? ptr - 1'b1 : ptr + 1'b1;
    end
  end

  always_comb begin
    emit            = 1'b0;
    rsp_next.data   = '0;
    rsp_next.status = psq_pkg::ST_OK;
    rsp_next.last   = 1'b1;
    if (ctrl.list_step) begin
      emit          = 1'b1;
      rsp_next.data = rd_data;
      rsp_next.last = stat.list_last;
    end else if (ctrl.accept) begin
      case (req.cmd)
        psq_pkg::CMD_INSERT: begin
          if (!ins_ok) begin
            emit            = 1'b1;
            rsp_next.status = psq_pkg::ST_ERR;
          end
        end
        psq_pkg::CMD_REMOVE: begin
          if (!pos_ok) begin
            emit            = 1'b1;
            rsp_next.status = psq_pkg::ST_ERR;
          end
        end
        psq_pkg::CMD_READ: begin
          emit = 1'b1;
          if (pos_ok) begin
            rsp_next.data = rd_data;
          end else begin
            rsp_next.status = psq_pkg::ST_ERR;
          end
        end
        psq_pkg::CMD_COUNT: begin
          emit          = 1'b1;
          rsp_next.data = 32'(count);
        end
        psq_pkg::CMD_LIST_FWD, psq_pkg::CMD_LIST_BWD: begin
          if (count == '0) begin
            emit            = 1'b1;
            rsp_next.status = psq_pkg::ST_EMPTY;
          end
        end
        default: emit = 1'b0;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (emit) begin
      rsp_valid <= 1'b1;
    end else if (rsp_ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      rsp <= rsp_next;
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count_x <= CMP_W'(CAPACITY))
    else $error("count above capacity");

  a_insert_grows: assert property (@(posedge clk) disable iff (rst)
    do_ins |=> count == $past(count) + 1'b1)
    else $error("insert did not advance count");

  a_step_has_work: assert property (@(posedge clk) disable iff (rst)
    ctrl.list_step |-> rem != '0)
    else $error("listing step with nothing left");

  a_no_overrun: assert property (@(posedge clk) disable iff (rst)
    emit |-> stat.out_free)
    else $error("result register overwritten");

endmodule
`default_nettype wire

// ===== rtl/core/positional_sequence_store.sv =====
// Top level of the positional sequence store.
`timescale 1ns / 1ps
`default_nettype none
// Ordered store of up to CAPACITY signed 32-bit words kept in a row of shifting
// cells. Insert, remove, read and count are handled on acceptance: the whole row
// shifts in parallel and a single result register holds any response. A listing
// sets up its pointer on acceptance, then gives one result per cycle while the
// response side is free, capped at 32 results, paced by the single read port on
// the cells and the result register; no new request is taken until the last
// listing result is loaded. Stalls on the response side hold the block. Reset
// clears count, rem, rsp_valid and state; the cells are not cleared and need not be.
module positional_sequence_store #(
  parameter int CAPACITY = 32
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          req_valid,
  output logic               req_ready,
  input  wire psq_pkg::req_t req,
  output logic               rsp_valid,
  input  wire logic          rsp_ready,
  output psq_pkg::rsp_t      rsp
);

  psq_pkg::ctrl_t ctrl;
  psq_pkg::stat_t stat;

  psq_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .stat      (stat),
    .ctrl      (ctrl)
  );

  psq_datapath #(
    .CAPACITY (CAPACITY)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .req       (req),
    .ctrl      (ctrl),
    .stat      (stat),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp)
  );

endmodule
`default_nettype wire

// ===== verif/positional_sequence_store_tb.sv =====
// Testbench for the positional sequence store: directed and random requests, scoreboard check.
`timescale 1ns / 1ps
module positional_sequence_store_tb;

  localparam int CAPACITY = 32;
  localparam int CYCLE_LIMIT = 1000000;
  localparam int HOLD_CYCLES = 300;
  localparam int DRAIN_CYCLES = 40;
  localparam logic [2:0] CMD_UNUSED_LO = 3'd6;
  localparam logic [2:0] CMD_UNUSED_HI = 3'd7;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic req_valid = 1'b0;
  logic req_ready;
  psq_pkg::req_t req = '0;
  logic rsp_valid;
  logic rsp_ready = 1'b0;
  psq_pkg::rsp_t rsp;

  logic signed [31:0] shadow_words [CAPACITY];
  int shadow_count = 0;
  psq_pkg::rsp_t awaited_rsp [$];
  int mismatches = 0;
  int cycles = 0;
  int burst_left = 0;
  int holds_asked = 0;

  positional_sequence_store #(
    .CAPACITY(CAPACITY)
  ) dut (
    .clk(clk),
    .rst(rst),
    .req_valid(req_valid),
    .req_ready(req_ready),
    .req(req),
    .rsp_valid(rsp_valid),
    .rsp_ready(rsp_ready),
    .rsp(rsp)
  );

  always #1 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d responses outstanding", cycles, awaited_rsp.size());
      $display("FAILURE");
      $finish;
    end
  end

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    if (mismatches < 30) begin
      $display("cycle %0d: %s mismatch, got %0h expected %0h", cycles, what, got, want);
    end
    mismatches++;
  endtask

  function automatic psq_pkg::rsp_t make_rsp(input logic [31:0] data,
                                             input logic [1:0] status, input logic last);
    psq_pkg::rsp_t r;
    r.data = data;
    r.status = status;
    r.last = last;
    return r;
  endfunction

  // Apply one accepted request to the shadow store and queue its responses.
  task automatic apply_to_shadow(input psq_pkg::req_t r);
    int n;
    case (r.cmd)
      psq_pkg::CMD_INSERT: begin
        if (int'(r.position) > shadow_count || shadow_count >= CAPACITY) begin
          awaited_rsp.push_back(make_rsp('0, psq_pkg::ST_ERR, 1'b1));
        end else begin
          for (int i = shadow_count; i > int'(r.position); i--) begin
            shadow_words[i] = shadow_words[i - 1];
          end
          shadow_words[int'(r.position)] = r.new_value;
          shadow_count++;
        end
      end
      psq_pkg::CMD_REMOVE: begin
        if (int'(r.position) >= shadow_count) begin
          awaited_rsp.push_back(make_rsp('0, psq_pkg::ST_ERR, 1'b1));
        end else begin
          for (int i = int'(r.position); i + 1 < shadow_count; i++) begin
            shadow_words[i] = shadow_words[i + 1];
          end
          shadow_count--;
        end
      end
      psq_pkg::CMD_READ: begin
        if (int'(r.position) >= shadow_count) begin
          awaited_rsp.push_back(make_rsp('0, psq_pkg::ST_ERR, 1'b1));
        end else begin
          awaited_rsp.push_back(make_rsp(shadow_words[int'(r.position)], psq_pkg::ST_OK,
                                         1'b1));
        end
      end
      psq_pkg::CMD_COUNT: begin
        awaited_rsp.push_back(make_rsp(32'(shadow_count), psq_pkg::ST_OK, 1'b1));
      end
      psq_pkg::CMD_LIST_FWD, psq_pkg::CMD_LIST_BWD: begin
        if (shadow_count == 0) begin
          awaited_rsp.push_back(make_rsp('0, psq_pkg::ST_EMPTY, 1'b1));
        end else begin
          n = (shadow_count > psq_pkg::MAX_RESULTS) ? psq_pkg::MAX_RESULTS : shadow_count;
          for (int i = 0; i < n; i++) begin
            awaited_rsp.push_back(make_rsp(
                shadow_words[(r.cmd == psq_pkg::CMD_LIST_BWD) ? shadow_count - 1 - i : i],
                psq_pkg::ST_OK, i + 1 == n));
          end
        end
      end
      default: begin
      end
    endcase
  endtask

  // Offer one request, with random gaps between bursts; keep valid high across a burst.
  task automatic send_request(input logic [2:0] cmd, input int position,
                              input logic [31:0] value);
    psq_pkg::req_t r;
    int gap;
    r.cmd = cmd;
    r.position = position[5:0];
    r.new_value = value;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(30, 80) : $urandom_range(1, 12);
      if (gap > 0) begin
        req_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    req_valid <= 1'b1;
    req <= r;
    do @(posedge clk); while (!(req_valid && req_ready));
    apply_to_shadow(r);
  endtask

  task automatic wait_drained();
    req_valid <= 1'b0;
    while (awaited_rsp.size() != 0) @(posedge clk);
  endtask

  function automatic logic [31:0] random_value();
    case ($urandom_range(0, 7))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return 32'hffff_ffff;
      3: return '0;
      default: return $urandom;
    endcase
  endfunction

  function automatic int valid_position();
    return (shadow_count == 0) ? 0 : $urandom_range(0, shadow_count - 1);
  endfunction

  // Check each accepted response against the oldest expectation.
  always @(posedge clk) begin
    psq_pkg::rsp_t want;
    if (!rst && rsp_valid && rsp_ready) begin
      if (awaited_rsp.size() == 0) begin
        report_mismatch("unexpected response", rsp.data, '0);
      end else begin
        want = awaited_rsp.pop_front();
        if (rsp.data !== want.data) report_mismatch("data", rsp.data, want.data);
        if (rsp.status !== want.status) begin
          report_mismatch("status", 32'(rsp.status), 32'(want.status));
        end
        if (rsp.last !== want.last) report_mismatch("last", 32'(rsp.last), 32'(want.last));
      end
    end
  end

  // Response-side stall patterns, plus long hold-offs on demand.
  initial begin
    int mode;
    int mode_left;
    int held;
    int holds_served;
    mode = 0;
    mode_left = 0;
    held = 0;
    holds_served = 0;
    forever begin
      @(posedge clk);
      if (holds_served != holds_asked) begin
        holds_served++;
        held = HOLD_CYCLES;
      end
      if (held > 0) begin
        held--;
        rsp_ready <= 1'b0;
      end else begin
        if (mode_left == 0) begin
          mode = $urandom_range(0, 3);
          mode_left = $urandom_range(10, 80);
        end
        mode_left--;
        case (mode)
          0: rsp_ready <= 1'b1;
          1: rsp_ready <= 1'($urandom_range(0, 1));
          2: rsp_ready <= (cycles % 4) != 0;
          default: rsp_ready <= ($urandom_range(0, 7) == 0);
        endcase
      end
    end
  end

  task automatic test_empty_store();
    send_request(psq_pkg::CMD_LIST_FWD, 0, '0);
    send_request(psq_pkg::CMD_LIST_BWD, 0, '0);
    send_request(psq_pkg::CMD_COUNT, 0, '0);
    send_request(psq_pkg::CMD_READ, 0, '0);
    send_request(psq_pkg::CMD_REMOVE, 0, '0);
    send_request(psq_pkg::CMD_INSERT, 1, 32'h1234_5678);
    send_request(psq_pkg::CMD_READ, 63, '0);
    send_request(CMD_UNUSED_LO, 63, 32'hffff_ffff);
    send_request(CMD_UNUSED_HI, 0, '0);
    wait_drained();
  endtask

  task automatic test_directed_edits();
    send_request(psq_pkg::CMD_INSERT, 0, 32'h8000_0000);
    send_request(psq_pkg::CMD_INSERT, 1, 32'h7fff_ffff);
    send_request(psq_pkg::CMD_INSERT, 1, 32'hffff_ffff);
    send_request(psq_pkg::CMD_INSERT, 0, '0);
    send_request(psq_pkg::CMD_INSERT, 2, 32'd1);
    send_request(psq_pkg::CMD_LIST_FWD, 0, '0);
    send_request(psq_pkg::CMD_LIST_BWD, 0, '0);
    send_request(psq_pkg::CMD_READ, 0, '0);
    send_request(psq_pkg::CMD_READ, 4, '0);
    send_request(psq_pkg::CMD_READ, 5, '0);
    send_request(psq_pkg::CMD_REMOVE, 4, '0);
    send_request(psq_pkg::CMD_REMOVE, 0, '0);
    send_request(psq_pkg::CMD_COUNT, 0, '0);
    send_request(psq_pkg::CMD_INSERT, 63, 32'h5555_aaaa);
    wait_drained();
  endtask

  task automatic test_full_store();
    while (shadow_count < CAPACITY) begin
      send_request(psq_pkg::CMD_INSERT, $urandom_range(0, shadow_count), random_value());
    end
    send_request(psq_pkg::CMD_INSERT, 0, random_value());
    send_request(psq_pkg::CMD_INSERT, CAPACITY, random_value());
    send_request(psq_pkg::CMD_COUNT, 0, '0);
    holds_asked++;
    for (int i = 0; i < 6; i++) begin
      send_request(i[0] ? psq_pkg::CMD_LIST_BWD : psq_pkg::CMD_LIST_FWD, 0, '0);
    end
    while (shadow_count > 0) begin
      send_request(psq_pkg::CMD_REMOVE, valid_position(), $urandom);
    end
    send_request(psq_pkg::CMD_LIST_BWD, 0, '0);
    wait_drained();
  endtask

  task automatic test_random_mix(input int items);
    int pick;
    int ins_pct;
    for (int k = 0; k < items; k++) begin
      pick = $urandom_range(0, 99);
      ins_pct = (shadow_count < 16) ? 45 : 25;
      if (pick < ins_pct) begin
        send_request(psq_pkg::CMD_INSERT, ($urandom_range(0, 9) == 0) ? $urandom_range(0, 63)
                     : $urandom_range(0, shadow_count), random_value());
      end else if (pick < ins_pct + 22) begin
        send_request(psq_pkg::CMD_REMOVE, ($urandom_range(0, 9) == 0) ? $urandom_range(0, 63)
                     : valid_position(), $urandom);
      end else if (pick < ins_pct + 37) begin
        send_request(psq_pkg::CMD_READ, ($urandom_range(0, 9) == 0) ? $urandom_range(0, 63)
                     : valid_position(), $urandom);
      end else if (pick < ins_pct + 43) begin
        send_request(psq_pkg::CMD_COUNT, $urandom_range(0, 63), $urandom);
      end else if (pick < ins_pct + 49) begin
        send_request(psq_pkg::CMD_LIST_FWD, $urandom_range(0, 63), $urandom);
      end else if (pick < ins_pct + 55) begin
        send_request(psq_pkg::CMD_LIST_BWD, $urandom_range(0, 63), $urandom);
      end else begin
        send_request(($urandom_range(0, 1) == 0) ? CMD_UNUSED_LO : CMD_UNUSED_HI,
                     $urandom_range(0, 63), $urandom);
        k--;
      end
    end
    wait_drained();
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_empty_store();
    test_directed_edits();
    test_full_store();
    test_random_mix(420);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0 && awaited_rsp.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
